### rtl/gauging_table_interpolator_unit_macros.svh
`ifndef GAUGING_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define GAUGING_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low
`define GTI_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while rst_n is low
`define GTI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gti_pkg.sv
`timescale 1ns / 1ps

package gti_pkg;

    // field widths
    localparam int VOL_W     = 32;
    localparam int IDX_W     = 16;
    localparam int STEP_W    = 31;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 1;

    // lookup arithmetic
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = VOL_W + FRAC_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_CYCLES = QUOT_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int MIN_POINTS = 2;

    // generation tag stored next to each volume
    localparam int EPOCH_W = 4;

    // operations
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // result status
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [ST_W-1:0] ST_BELOW     = 3'd2;
    localparam logic [ST_W-1:0] ST_TOP       = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP   = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [IDX_W-1:0]        point_index;
        logic signed [VOL_W-1:0] point_volume;
        logic signed [VOL_W-1:0] level;
    } in_item_t;

    typedef struct packed {
        logic signed [VOL_W-1:0] volume;
        logic [ST_W-1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [VOL_W-1:0]     data;
    } cfg_item_t;

    // divider request and status
    typedef struct packed {
        logic              start;
        logic [VOL_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/gti_chan_if.sv
`timescale 1ns / 1ps

// valid/ready channel carrying one payload per transfer
interface gti_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/gti_ram.sv
`timescale 1ns / 1ps

// single write port, single read port, registered read
module gti_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/gti_div.sv
`timescale 1ns / 1ps

// Restoring divider, DIV_BITS quotient bits per cycle.
// quotient = floor(dividend * 2^FRAC_W / divisor), divisor nonzero.
module gti_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gti_pkg::div_req_t                req,
    output gti_pkg::div_stat_t               stat,
    output logic [gti_pkg::QUOT_W-1:0]       quotient
);

    logic [gti_pkg::STEP_W-1:0]    rem_reg, rem_next;
    logic [gti_pkg::QUOT_W-1:0]    num_reg, num_next;
    logic [gti_pkg::STEP_W-1:0]    divisor_reg;
    logic [gti_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    // DIV_BITS dependent shift-subtract steps
    always_comb
    begin
        logic [gti_pkg::STEP_W:0] trial;
        logic [gti_pkg::STEP_W:0] diff;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int i = 0; i < gti_pkg::DIV_BITS; i++)
        begin
            trial = {rem_next, num_next[gti_pkg::QUOT_W-1]};
            diff  = trial - {1'b0, divisor_reg};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = diff[gti_pkg::STEP_W-1:0];
                num_next = {num_next[gti_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gti_pkg::STEP_W-1:0];
                num_next = {num_next[gti_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    // iteration control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gti_pkg::DIV_CNT_W'(gti_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            num_reg     <= {req.dividend, {gti_pkg::FRAC_W{1'b0}}};
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

### rtl/gauging_table_interpolator_unit.sv
`timescale 1ns / 1ps

// Channel   Modport  Payload       Carries
// items     sink     in_item_t     operation, point_index, point_volume, level
// results   source   out_item_t    volume, status
// cfg       sink     cfg_item_t    index, data (start_height, level_step)
//
// Lookup: the divider retires 2 of 48 quotient bits a cycle, then the point memory is
// read twice (once when clamped at the top). Read point makes one memory read; write
// point, clear and errors go straight from the item to the emit state.
// After reset, and after every fifteenth clear, a clearing pass over all MAX_POINTS
// entries resets the entry tags; items wait during it, cfg writes are always taken.
// Results sit in an output register, so a stalled results channel holds one finished
// item and the next item is still taken and worked on.

`include "gauging_table_interpolator_unit_macros.svh"

module gauging_table_interpolator_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    gti_chan_if.sink   items,
    gti_chan_if.source results,
    gti_chan_if.sink   cfg
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int RAM_W = gti_pkg::EPOCH_W + gti_pkg::VOL_W;
    localparam int VW    = gti_pkg::VOL_W;
    localparam int PW    = gti_pkg::FRAC_W + 1 + VW + 1;

    localparam logic [3:0] S_SWEEP    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ENT_WAIT = 4'd2;
    localparam logic [3:0] S_ENT_DATA = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_V1_WAIT  = 4'd5;
    localparam logic [3:0] S_V1_DATA  = 4'd6;
    localparam logic [3:0] S_V2_DATA  = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    // control state
    logic [3:0]                    state_reg, state_next;
    logic [AW-1:0]                 sweep_cnt_reg, sweep_cnt_next;
    logic                          sweep_pend_reg, sweep_pend_next;
    logic [gti_pkg::EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [CW-1:0]                 point_count_reg, point_count_next;
    logic                          table_valid_reg, table_valid_next;
    logic                          out_valid_reg, out_valid_next;

    // configuration
    logic [VW-1:0]                 start_height_reg;
    logic [gti_pkg::STEP_W-1:0]    level_step_reg;

    // datapath
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [gti_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [VW-1:0]                 v1_reg, v1_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic [VW-1:0]                 res_vol_reg, res_vol_next;
    logic [gti_pkg::ST_W-1:0]      res_st_reg, res_st_next;
    logic [VW-1:0]                 out_vol_reg, out_vol_next;
    logic [gti_pkg::ST_W-1:0]      out_st_reg, out_st_next;

    // memory and divider hookup
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [RAM_W-1:0]              ram_wdata;
    logic [RAM_W-1:0]              ram_rdata;
    gti_pkg::div_req_t             div_req;
    gti_pkg::div_stat_t            div_stat;
    logic [gti_pkg::QUOT_W-1:0]    quotient;

    // decode helpers
    logic                          in_accept;
    logic                          idx_ok;
    logic [VW:0]                   lvl_diff;
    logic [gti_pkg::STEP_W-1:0]    step_eff;
    logic [CW-1:0]                 last_idx;
    logic [VW-1:0]                 quot_int;
    logic [VW-1:0]                 ent;
    logic [VW:0]                   dv;
    logic signed [gti_pkg::FRAC_W:0] frac_s;
    logic [VW+1:0]                 interp_sum;

    assign items.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign in_accept   = items.valid && items.ready;

    assign idx_ok   = items.payload.point_index < gti_pkg::IDX_W'(MAX_POINTS);
    assign lvl_diff = {items.payload.level[VW-1], items.payload.level}
                    - {start_height_reg[VW-1], start_height_reg};
    assign step_eff = (level_step_reg == '0) ? gti_pkg::STEP_W'(1) : level_step_reg;
    assign last_idx = point_count_reg - CW'(1);
    assign quot_int = quotient[gti_pkg::QUOT_W-1 -: VW];

    // stored entry counts only when its tag matches the current generation
    assign ent = (ram_rdata[RAM_W-1 -: gti_pkg::EPOCH_W] == epoch_reg)
               ? ram_rdata[VW-1:0] : '0;

    // frac * (v2 - v1), v2 taken straight from the read port
    assign dv        = {ent[VW-1], ent} - {v1_reg[VW-1], v1_reg};
    assign frac_s    = $signed({1'b0, frac_reg});
    assign prod_next = frac_s * $signed(dv);

    // v1 + floor(product / 2^16)
    assign interp_sum = {{2{v1_reg[VW-1]}}, v1_reg}
                      + prod_reg[PW-1 -: (VW + 2)];

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        sweep_pend_next  = sweep_pend_reg;
        epoch_next       = epoch_reg;
        point_count_next = point_count_reg;
        table_valid_next = table_valid_reg;
        out_valid_next   = out_valid_reg;
        addr_next        = addr_reg;
        frac_next        = frac_reg;
        v1_next          = v1_reg;
        res_vol_next     = res_vol_reg;
        res_st_next      = res_st_reg;
        out_vol_next     = out_vol_reg;
        out_st_next      = out_st_reg;
        ram_we           = 1'b0;
        ram_waddr        = items.payload.point_index[AW-1:0];
        ram_wdata        = {epoch_reg, items.payload.point_volume};
        div_req.start    = 1'b0;
        div_req.dividend = lvl_diff[VW-1:0];
        div_req.divisor  = step_eff;

        // output register drains on its own
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = '0;
                if (sweep_cnt_reg == AW'(MAX_POINTS - 1))
                begin
                    sweep_cnt_next  = '0;
                    sweep_pend_next = 1'b0;
                    epoch_next      = gti_pkg::EPOCH_W'(1);
                    state_next      = S_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_vol_next = '0;
                    res_st_next  = gti_pkg::ST_OK;
                    state_next   = S_EMIT;
                    unique case (items.payload.operation)
                        gti_pkg::OP_WRITE:
                        begin
                            if (!idx_ok)
                            begin
                                res_st_next = gti_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                table_valid_next = 1'b1;
                                if (items.payload.point_index
                                    >= gti_pkg::IDX_W'(point_count_reg))
                                begin
                                    point_count_next =
                                        CW'(items.payload.point_index[AW-1:0]) + CW'(1);
                                end
                            end
                        end

                        gti_pkg::OP_CLEAR:
                        begin
                            point_count_next = '0;
                            table_valid_next = 1'b0;
                            epoch_next       = epoch_reg + 1'b1;
                            // tags wrap: old entries must be wiped before reuse
                            if (&epoch_reg)
                            begin
                                sweep_pend_next = 1'b1;
                            end
                        end

                        gti_pkg::OP_READ:
                        begin
                            if (!idx_ok)
                            begin
                                res_st_next = gti_pkg::ST_BAD_INDEX;
                            end
                            else if (!table_valid_reg)
                            begin
                                res_st_next = gti_pkg::ST_NOT_READY;
                            end
                            else
                            begin
                                addr_next  = items.payload.point_index[AW-1:0];
                                state_next = S_ENT_WAIT;
                            end
                        end

                        gti_pkg::OP_LOOKUP:
                        begin
                            if (!table_valid_reg
                                || point_count_reg < CW'(gti_pkg::MIN_POINTS))
                            begin
                                res_st_next = gti_pkg::ST_NOT_READY;
                            end
                            else if (lvl_diff[VW])
                            begin
                                res_st_next = gti_pkg::ST_BELOW;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                    endcase
                end
            end

            S_ENT_WAIT:
            begin
                state_next = S_ENT_DATA;
            end

            S_ENT_DATA:
            begin
                res_vol_next = ent;
                state_next   = S_EMIT;
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (quot_int >= VW'(last_idx))
                    begin
                        addr_next   = last_idx[AW-1:0];
                        res_st_next = gti_pkg::ST_TOP;
                        state_next  = S_ENT_WAIT;
                    end
                    else
                    begin
                        addr_next  = quot_int[AW-1:0];
                        frac_next  = quotient[gti_pkg::FRAC_W-1:0];
                        state_next = S_V1_WAIT;
                    end
                end
            end

            S_V1_WAIT:
            begin
                // memory samples q now, q+1 next cycle
                addr_next  = addr_reg + 1'b1;
                state_next = S_V1_DATA;
            end

            S_V1_DATA:
            begin
                v1_next    = ent;
                state_next = S_V2_DATA;
            end

            S_V2_DATA:
            begin
                state_next = S_MUL;
            end

            S_MUL:
            begin
                res_vol_next = interp_sum[VW-1:0];
                state_next   = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vol_next   = res_vol_reg;
                    out_st_next    = res_st_reg;
                    state_next     = sweep_pend_reg ? S_SWEEP : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_cnt_reg   <= '0;
            sweep_pend_reg  <= 1'b0;
            epoch_reg       <= '0;
            point_count_reg <= '0;
            table_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            sweep_pend_reg  <= sweep_pend_next;
            epoch_reg       <= epoch_next;
            point_count_reg <= point_count_next;
            table_valid_reg <= table_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        frac_reg    <= frac_next;
        v1_reg      <= v1_next;
        prod_reg    <= prod_next;
        res_vol_reg <= res_vol_next;
        res_st_reg  <= res_st_next;
        out_vol_reg <= out_vol_next;
        out_st_reg  <= out_st_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_height_reg <= '0;
            level_step_reg   <= gti_pkg::STEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.payload.index)
                gti_pkg::CFG_START_HEIGHT:
                begin
                    start_height_reg <= cfg.payload.data;
                end
                gti_pkg::CFG_LEVEL_STEP:
                begin
                    level_step_reg <= cfg.payload.data[gti_pkg::STEP_W-1:0];
                end
            endcase
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.payload.volume = out_vol_reg;
    assign results.payload.status = out_st_reg;

    // point memory: generation tag and volume per entry
    gti_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    gti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    `GTI_ASSERT_IMPLIES(a_div_busy_in_div, div_stat.busy, state_reg == S_DIV,
        "divider running outside the divide state")
    `GTI_ASSERT_IMPLIES(a_div_done_in_div, div_stat.done, state_reg == S_DIV,
        "divider result with no lookup waiting")
    `GTI_ASSERT_IMPLIES(a_valid_tracks_count, 1'b1,
        table_valid_reg == (point_count_reg != '0),
        "table valid flag disagrees with point count")
    `GTI_ASSERT_NEXT(a_clear_empties,
        items.valid && items.ready && items.payload.operation == gti_pkg::OP_CLEAR,
        !table_valid_reg && point_count_reg == '0,
        "clear left points in the table")
    `GTI_ASSERT_IMPLIES(a_live_epoch, state_reg == S_IDLE, epoch_reg != '0,
        "taking items with the swept tag as live generation")

endmodule
